### design/spmv_pkg.sv
// Shared widths, codes and stage beat types for the CSR sparse matrix-vector unit.
package spmv_pkg;

    // Item and result field widths
    localparam int MODE_W  = 2;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 12;
    localparam int ROW_W   = 16;
    localparam int ACC_W   = 64;

    // Vector memory depth default
    localparam int VECTOR_DEPTH_DEF = 4096;

    // Configuration port
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_SEL_LSB = 2;
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic [ROW_W-1:0] ROW_COUNT_RESET = ROW_W'(1);

    // Saturation bounds
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Item modes; the fourth code is unused and dropped
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_NONZERO = 2'd1,
        MODE_EMPTY   = 2'd2
    } mode_t;

    // Beat from the vector read stage into the multiply-accumulate unit
    typedef struct packed {
        logic                    valid;
        logic                    empty;
        logic                    row_end;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] vec;
    } mac_item_t;

    // Closed row sum handed to the rounding stage
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
    } sum_beat_t;

endpackage

### design/spmv_if.sv
// Valid/ready channel interfaces for input items and row results.
interface spmv_in_if import spmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    mode_t                   mode;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    row_end;

    modport source (output valid, mode, value, index, row_end, input ready);
    modport sink   (input valid, mode, value, index, row_end, output ready);
endinterface

interface spmv_out_if import spmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] row_value;
    logic                    last_row;
    logic                    saturated;

    modport source (output valid, row_index, row_value, last_row, saturated, input ready);
    modport sink   (input valid, row_index, row_value, last_row, saturated, output ready);
endinterface

### design/spmv_vec_mem.sv
// Dense vector storage: one write port, one read port with registered data.
module spmv_vec_mem import spmv_pkg::*; #(
    parameter int DEPTH = VECTOR_DEPTH_DEF,
    parameter int AW    = 12
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [VAL_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic signed [VAL_W-1:0] rdata
);

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/spmv_mac.sv
// Product stage and saturating Q32.32 row accumulator.
module spmv_mac import spmv_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  mac_item_t m_in,
    output logic      m_take,
    input  logic      s_ready,
    output sum_beat_t s_out
);

    logic                    p_valid_reg;
    logic                    p_emit_reg;
    logic signed [ACC_W-1:0] p_prod_reg;
    logic signed [ACC_W-1:0] p_prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [ACC_W:0]          sum_wide;
    logic [ACC_W-1:0]        sum_sat;
    logic                    p_move;

    // Product stage advances unless a closing beat waits on rounding
    assign p_move = !p_valid_reg || !p_emit_reg || s_ready;
    assign m_take = p_move;

    // Exact Q32.32 product, signed 32 by 32 into 64 bits; an empty row adds nothing
    always_comb
    begin
        if (m_in.empty)
        begin
            p_prod_next = '0;
        end
        else
        begin
            p_prod_next = m_in.value * m_in.vec;
        end
    end

    // Saturating add of the product into the accumulator
    always_comb
    begin
        sum_wide = {acc_reg[ACC_W-1], acc_reg} + {p_prod_reg[ACC_W-1], p_prod_reg};
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (p_valid_reg && p_move)
        begin
            acc_next = p_emit_reg ? '0 : sum_sat;
        end
    end

    assign s_out.valid = p_valid_reg && p_emit_reg;
    assign s_out.sum   = sum_sat;

    // Control and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_emit_reg  <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (p_move)
            begin
                p_valid_reg <= m_in.valid;
                p_emit_reg  <= m_in.empty || m_in.row_end;
            end
        end
    end

    // Product payload
    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            p_prod_reg <= p_prod_next;
        end
    end

    // A closed row leaves the accumulator cleared
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_emit_reg && s_ready) |=> (acc_reg == '0))
        else $error("accumulator not cleared after row close");

endmodule

### design/spmv_round.sv
// Round-to-Q16.16 stage, row counter and output register.
module spmv_round import spmv_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ROW_W-1:0] row_count,
    input  sum_beat_t        s_in,
    output logic             s_ready,
    spmv_out_if.source       result
);

    logic                    s_valid_reg;
    logic signed [ACC_W-1:0] s_sum_reg;
    logic                    o_valid_reg;
    logic [ROW_W-1:0]        o_index_reg;
    logic [VAL_W-1:0]        o_value_reg;
    logic                    o_last_reg;
    logic                    o_sat_reg;
    logic [ROW_W-1:0]        row_ctr_reg;
    logic [ROW_W-1:0]        row_ctr_next;
    logic [ROW_W-1:0]        last_idx;
    logic                    is_last;
    logic [ACC_W-16:0]       rnd;
    logic                    rnd_sat;
    logic [VAL_W-1:0]        rnd_val;
    logic                    o_free;
    logic                    o_load;

    assign o_free  = !o_valid_reg || result.ready;
    assign s_ready = !s_valid_reg || o_free;
    assign o_load  = s_valid_reg && o_free;

    // Round half up at bit 15, then clip to 32 bits
    always_comb
    begin
        rnd = {s_sum_reg[ACC_W-1], s_sum_reg[ACC_W-1:16]}
            + {{(ACC_W-16){1'b0}}, s_sum_reg[15]};
        rnd_sat = !((&rnd[ACC_W-16:VAL_W-1]) || !(|rnd[ACC_W-16:VAL_W-1]));
        if (rnd_sat)
        begin
            rnd_val = rnd[ACC_W-16] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            rnd_val = rnd[VAL_W-1:0];
        end
    end

    // Row index step with wrap; a zero count means the full 16-bit range
    always_comb
    begin
        last_idx     = row_count - ROW_W'(1);
        is_last      = (row_ctr_reg == last_idx);
        row_ctr_next = is_last ? '0 : row_ctr_reg + ROW_W'(1);
        if ((row_count != '0) && (row_ctr_next >= row_count))
        begin
            row_ctr_next = '0;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            row_ctr_reg <= '0;
        end
        else
        begin
            if (s_ready)
            begin
                s_valid_reg <= s_in.valid;
            end
            if (o_load)
            begin
                o_valid_reg <= 1'b1;
                row_ctr_reg <= row_ctr_next;
            end
            else if (result.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_ready)
        begin
            s_sum_reg <= s_in.sum;
        end
        if (o_load)
        begin
            o_index_reg <= row_ctr_reg;
            o_value_reg <= rnd_val;
            o_last_reg  <= is_last;
            o_sat_reg   <= rnd_sat;
        end
    end

    assign result.valid     = o_valid_reg;
    assign result.row_index = o_index_reg;
    assign result.row_value = o_value_reg;
    assign result.last_row  = o_last_reg;
    assign result.saturated = o_sat_reg;

    // Row counter stays below a nonzero row count after each step
    a_ctr_range: assert property (@(posedge clk) disable iff (!rst_n)
        o_load |=> (($past(row_count) == '0) || (row_ctr_reg < $past(row_count))))
        else $error("row counter beyond row count");

    // A clipped row carries one of the two bounds
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_sat_reg) |-> ((o_value_reg == VAL_MAX) || (o_value_reg == VAL_MIN)))
        else $error("saturated result not at a bound");

endmodule

### design/csr_sparse_matrix_vector_multiply_unit.sv
// Top level: APB register, address stage, vector read stage and result path.
//
//  channel  | dir | handshake      | beat
//  ---------+-----+----------------+---------------------------------------
//  item     | in  | valid/ready    | mode, value, index, row_end
//  result   | out | valid/ready    | row_index, row_value, last_row, saturated
//  apb      | in  | psel/penable   | row_count write/read, pready tied high
//
// One item per cycle sustained unless result stalls; the vector memory's
// single read port sets this. After its closing item is accepted, a row
// result passes address, vector read, product, accumulate, round/output.
// Reset clears stage valids, the accumulator and row counter, and sets
// row_count to one; vector memory has no reset and needs no clearing pass.
// A stall on result backs up only as far as the first empty stage.
module csr_sparse_matrix_vector_multiply_unit import spmv_pkg::*; #(
    parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    spmv_in_if.sink               item,
    spmv_out_if.source            result
);

    localparam int AW      = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int SH      = IDX_W + AW;
    localparam longint unsigned RECIP =
        ((longint'(1) << SH) + longint'(VECTOR_DEPTH) - 1) / longint'(VECTOR_DEPTH);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int QP_W    = IDX_W + RECIP_W;

    logic [ROW_W-1:0]        row_count_reg;
    logic                    reg_wr;

    logic                    a_valid_reg;
    mode_t                   a_mode_reg;
    logic signed [VAL_W-1:0] a_value_reg;
    logic [IDX_W-1:0]        a_index_reg;
    logic                    a_end_reg;
    logic [IDX_W-1:0]        a_quot_reg;
    logic [QP_W-1:0]         quot_prod;
    logic [IDX_W-1:0]        a_rem;
    logic [AW-1:0]           a_addr;
    logic                    a_to_m;
    logic                    a_move;
    logic                    a_fire;

    logic                    m_valid_reg;
    logic                    m_empty_reg;
    logic                    m_end_reg;
    logic signed [VAL_W-1:0] m_value_reg;
    logic                    m_ready;
    logic signed [VAL_W-1:0] vec_rdata;

    mac_item_t               mac_in;
    logic                    mac_take;
    sum_beat_t               sum_beat;
    logic                    sum_ready;

    // APB register
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[REG_SEL_LSB] == REG_ROW_COUNT);
    assign prdata = (paddr[REG_SEL_LSB] == REG_ROW_COUNT)
                  ? APB_DATA_W'(row_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
        end
        else if (reg_wr)
        begin
            row_count_reg <= pwdata[ROW_W-1:0];
        end
    end

    // Index modulo depth: reciprocal quotient at accept, remainder next
    assign quot_prod = QP_W'(item.index) * QP_W'(RECIP);

    always_comb
    begin
        a_rem  = a_index_reg - IDX_W'(a_quot_reg * VECTOR_DEPTH);
        a_addr = AW'(a_rem);
    end

    // Address stage flow
    always_comb
    begin
        case (a_mode_reg)
            MODE_NONZERO: a_to_m = 1'b1;
            MODE_EMPTY:   a_to_m = 1'b1;
            default:      a_to_m = 1'b0;
        endcase
    end

    assign m_ready    = !m_valid_reg || mac_take;
    assign a_move     = !a_valid_reg || !a_to_m || m_ready;
    assign a_fire     = a_valid_reg && a_move;
    assign item.ready = a_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_move)
            begin
                a_valid_reg <= item.valid;
            end
            if (m_ready)
            begin
                m_valid_reg <= a_fire && a_to_m;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            a_mode_reg  <= item.mode;
            a_value_reg <= item.value;
            a_index_reg <= item.index;
            a_end_reg   <= item.row_end;
            a_quot_reg  <= IDX_W'(quot_prod >> SH);
        end
        if (m_ready)
        begin
            m_empty_reg <= (a_mode_reg == MODE_EMPTY);
            m_end_reg   <= a_end_reg;
            m_value_reg <= a_value_reg;
        end
    end

    // Vector memory: loads write, nonzeros read
    spmv_vec_mem #(
        .DEPTH (VECTOR_DEPTH),
        .AW    (AW)
    ) u_vec_mem (
        .clk   (clk),
        .we    (a_fire && (a_mode_reg == MODE_LOAD)),
        .waddr (a_addr),
        .wdata (a_value_reg),
        .re    (a_fire && (a_mode_reg == MODE_NONZERO)),
        .raddr (a_addr),
        .rdata (vec_rdata)
    );

    assign mac_in.valid   = m_valid_reg;
    assign mac_in.empty   = m_empty_reg;
    assign mac_in.row_end = m_end_reg;
    assign mac_in.value   = m_value_reg;
    assign mac_in.vec     = vec_rdata;

    spmv_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .m_in    (mac_in),
        .m_take  (mac_take),
        .s_ready (sum_ready),
        .s_out   (sum_beat)
    );

    spmv_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_count (row_count_reg),
        .s_in      (sum_beat),
        .s_ready   (sum_ready),
        .result    (result)
    );

    // Input backpressure only comes from an occupied address stage
    a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (a_valid_reg && a_to_m && m_valid_reg))
        else $error("input stalled with free address stage");

    // A vector read never overwrites data still held by the read stage
    a_read_free: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && (a_mode_reg == MODE_NONZERO)) |-> m_ready)
        else $error("vector read while read stage busy");

endmodule
